// ===== rtl/streaming_quantile_sketch_defines.svh =====
// Assertion helpers for the quantile sketch.
`ifndef STREAMING_QUANTILE_SKETCH_DEFINES_SVH
`define STREAMING_QUANTILE_SKETCH_DEFINES_SVH

`ifndef SYNTHESIS
`define SQS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sketch check failed");
`define SQS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sketch check failed");
`else
`define SQS_ASSERT_SAME(label, ante, cons)
`define SQS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/sqs_pkg.sv =====
package sqs_pkg;

  localparam int K           = 200;
  localparam int MAX_LEVELS  = 16;
  localparam int STORE_DEPTH = MAX_LEVELS * (K + 1);
  localparam int DATA_W      = 32;
  localparam int FILL_W      = 11;
  localparam int SCR_DEPTH   = 1 << FILL_W;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int LVL_W       = $clog2(MAX_LEVELS + 1);
  localparam int LIDX_W      = $clog2(MAX_LEVELS);
  localparam int TOT_W       = CNT_W + MAX_LEVELS - 1;
  localparam int FRAC_W      = 17;
  localparam int DCNT_W      = $clog2(FRAC_W);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [LVL_W-1:0] active;
    logic             ovf;
  } sqs_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_FIND,
    S_BASE,
    S_LD_RD,
    S_LD_WT,
    S_SRT_RD,
    S_SRT_CMP,
    S_KEEP_RD,
    S_KEEP_WR,
    S_MV_RD,
    S_MV_WR,
    S_FIX,
    S_Q_LV,
    S_Q_ACC,
    S_DIV,
    S_OUT
  } state_t;

  typedef logic [FILL_W-1:0] cap_arr_t [MAX_LEVELS];
  typedef logic [CNT_W-1:0]  max_arr_t [MAX_LEVELS+1];

  // capacity at depth d: ceil(K * 2^d / 3^d) + 1
  function automatic cap_arr_t cap_table();
    cap_arr_t    t;
    longint      num;
    longint      den;
    longint      q;
    for (int d = 0; d < MAX_LEVELS; d++) begin
      num = longint'(K) << d;
      den = 1;
      for (int i = 0; i < d; i++) den = den * 3;
      // smallest q with q * den >= num
      q = 0;
      while (q * den < num) q = q + 1;
      t[d] = FILL_W'(q + 1);
    end
    return t;
  endfunction

  localparam cap_arr_t CAP_TAB = cap_table();

  // summed capacity for a given number of active levels
  function automatic max_arr_t max_table();
    max_arr_t t;
    int       s;
    s = 0;
    t[0] = '0;
    for (int a = 1; a <= MAX_LEVELS; a++) begin
      s = s + int'(CAP_TAB[a-1]);
      t[a] = CNT_W'(s);
    end
    return t;
  endfunction

  localparam max_arr_t MAX_TAB = max_table();

endpackage

// ===== rtl/sqs_ram.sv =====
module sqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sqs_front.sv =====
module sqs_front import sqs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [DATA_W-1:0] in_value,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cls;

  always_comb begin
    cls.value = in_value;
    unique case (in_op)
      1'b0:    cls.op = OP_INSERT;
      default: cls.op = OP_QUERY;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

// ===== rtl/sqs_back.sv =====
module sqs_back import sqs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic              cfg_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [16:0]       out_cdf_fraction,
  output logic [31:0]       out_total_weight,
  output logic [4:0]        out_levels_in_use,
  output logic              out_overflow,
  output sqs_stat_t         stat
);

  state_t             state_r, state_nxt;
  logic [FILL_W-1:0]  fill_r [MAX_LEVELS];
  logic [FILL_W-1:0]  fill_nxt [MAX_LEVELS];
  logic [LVL_W-1:0]   active_r, active_nxt;
  logic [CNT_W-1:0]   stored_r, stored_nxt;
  logic               ovf_r, ovf_nxt;

  logic [LIDX_W-1:0]  lvl_r, lvl_nxt;
  logic [LIDX_W-1:0]  scan_r, scan_nxt;
  logic [CNT_W-1:0]   base_r, base_nxt;
  logic [FILL_W-1:0]  n_r, n_nxt;
  logic [FILL_W-1:0]  i_r, i_nxt;
  logic [FILL_W-1:0]  j_r, j_nxt;
  logic [FILL_W-1:0]  k_r, k_nxt;
  logic [FILL_W:0]    t_r, t_nxt;
  logic [DATA_W-1:0]  v_r, v_nxt;
  logic [CNT_W-1:0]   src_r, src_nxt;
  logic [CNT_W-1:0]   dst_r, dst_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;

  logic [LIDX_W-1:0]  qlv_r, qlv_nxt;
  logic [FILL_W-1:0]  qleft_r, qleft_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [DATA_W-1:0]  qv_r, qv_nxt;
  logic [TOT_W-1:0]   tot_r, tot_nxt;
  logic [TOT_W-1:0]   below_r, below_nxt;
  logic [TOT_W:0]     rem_r, rem_nxt;
  logic [FRAC_W-1:0]  quo_r, quo_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;

  logic               ov_r, ov_nxt;
  logic [16:0]        ocdf_r, ocdf_nxt;
  logic [31:0]        otot_r, otot_nxt;
  logic [4:0]         olvl_r, olvl_nxt;
  logic               oovf_r, oovf_nxt;

  logic               st_we;
  logic [ADDR_W-1:0]  st_wa, st_ra;
  logic [DATA_W-1:0]  st_wd, st_rd;
  logic               sc_we;
  logic [FILL_W-1:0]  sc_wa, sc_ra;
  logic [DATA_W-1:0]  sc_wd, sc_rd;

  logic [LVL_W-1:0]   cap_d;
  logic               lvl_full;
  logic               find_last;
  logic [LIDX_W-1:0]  top_idx;
  logic [LIDX_W-1:0]  qlv_dn;
  logic               ge;
  logic [TOT_W:0]     rem_sub;
  logic [TOT_W-1:0]   rem_keep;
  logic [TOT_W-1:0]   qw;
  logic [63:0]        tot64;
  logic               out_free;
  logic               store_full;
  logic               srt_move;

  sqs_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_wa),
    .wdata (st_wd),
    .raddr (st_ra),
    .rdata (st_rd)
  );

  sqs_ram #(.WIDTH(DATA_W), .DEPTH(SCR_DEPTH)) u_scratch (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_wa),
    .wdata (sc_wd),
    .raddr (sc_ra),
    .rdata (sc_rd)
  );

  // levels live top-down in the store, so level 0 always ends at stored_r
  assign cap_d      = active_r - LVL_W'(1) - LVL_W'(lvl_r);
  assign lvl_full   = fill_r[lvl_r] >= CAP_TAB[cap_d[LIDX_W-1:0]];
  assign find_last  = (LVL_W'(lvl_r) + LVL_W'(1)) >= active_r;
  assign top_idx    = LIDX_W'(active_r - LVL_W'(1));
  assign qlv_dn     = qlv_r - LIDX_W'(1);
  assign ge         = rem_r >= {1'b0, tot_r};
  assign rem_sub    = rem_r - {1'b0, tot_r};
  assign rem_keep   = ge ? rem_sub[TOT_W-1:0] : rem_r[TOT_W-1:0];
  assign qw         = TOT_W'(1) << qlv_r;
  assign tot64      = 64'(tot_r);
  assign out_free   = !ov_r || !out_stall;
  assign store_full = stored_r >= CNT_W'(STORE_DEPTH);
  assign srt_move   = $signed(sc_rd) > $signed(v_r);

  assign out_valid         = ov_r;
  assign out_cdf_fraction  = ocdf_r;
  assign out_total_weight  = otot_r;
  assign out_levels_in_use = olvl_r;
  assign out_overflow      = oovf_r;
  assign stat.active       = active_r;
  assign stat.ovf          = ovf_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_QUERY) begin
            state_nxt = S_Q_LV;
          end else if (!store_full) begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK:     state_nxt = (stored_r >= MAX_TAB[active_r]) ? S_FIND : S_IDLE;
      S_FIND: begin
        if (lvl_full) begin
          state_nxt = S_BASE;
        end else if (find_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_BASE:    if (scan_r == lvl_r) state_nxt = S_LD_RD;
      S_LD_RD:   state_nxt = (i_r == n_r) ? S_KEEP_RD : S_LD_WT;
      S_LD_WT:   state_nxt = S_SRT_RD;
      S_SRT_RD:  state_nxt = (j_r == '0) ? S_LD_RD : S_SRT_CMP;
      S_SRT_CMP: state_nxt = srt_move ? S_SRT_RD : S_LD_RD;
      S_KEEP_RD: state_nxt = (t_r >= {1'b0, n_r}) ? S_MV_RD : S_KEEP_WR;
      S_KEEP_WR: state_nxt = S_KEEP_RD;
      S_MV_RD:   state_nxt = (left_r == '0) ? S_FIX : S_MV_WR;
      S_MV_WR:   state_nxt = S_MV_RD;
      S_FIX:     state_nxt = S_IDLE;
      S_Q_LV: begin
        if (idx_r == stored_r) begin
          state_nxt = (tot_r == '0) ? S_OUT : S_DIV;
        end else if (qleft_r != '0) begin
          state_nxt = S_Q_ACC;
        end
      end
      S_Q_ACC:   state_nxt = S_Q_LV;
      S_DIV:     if (dcnt_r == DCNT_W'(FRAC_W - 1)) state_nxt = S_OUT;
      S_OUT:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    fill_nxt   = fill_r;
    active_nxt = active_r;
    stored_nxt = stored_r;
    ovf_nxt    = ovf_r;
    lvl_nxt    = lvl_r;
    scan_nxt   = scan_r;
    base_nxt   = base_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    t_nxt      = t_r;
    v_nxt      = v_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    left_nxt   = left_r;
    qlv_nxt    = qlv_r;
    qleft_nxt  = qleft_r;
    idx_nxt    = idx_r;
    qv_nxt     = qv_r;
    tot_nxt    = tot_r;
    below_nxt  = below_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dcnt_nxt   = dcnt_r;
    ocdf_nxt   = ocdf_r;
    otot_nxt   = otot_r;
    olvl_nxt   = olvl_r;
    oovf_nxt   = oovf_r;
    ov_nxt     = ov_r && out_stall;
    cmd_pop    = 1'b0;
    st_we      = 1'b0;
    st_wa      = stored_r[ADDR_W-1:0];
    st_wd      = cmd.value;
    st_ra      = src_r[ADDR_W-1:0];
    sc_we      = 1'b0;
    sc_wa      = j_r;
    sc_wd      = v_r;
    sc_ra      = j_r - FILL_W'(1);

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_QUERY) begin
            qlv_nxt   = top_idx;
            qleft_nxt = fill_r[top_idx];
            idx_nxt   = '0;
            qv_nxt    = cmd.value;
            tot_nxt   = '0;
            below_nxt = '0;
          end else if (!store_full) begin
            st_we       = 1'b1;
            fill_nxt[0] = fill_r[0] + FILL_W'(1);
            stored_nxt  = stored_r + CNT_W'(1);
          end
        end
        lvl_nxt = '0;
      end
      S_FIND: begin
        if (lvl_full) begin
          scan_nxt = top_idx;
          base_nxt = '0;
        end else begin
          lvl_nxt = lvl_r + LIDX_W'(1);
        end
      end
      S_BASE: begin
        if (scan_r == lvl_r) begin
          n_nxt = fill_r[lvl_r];
          i_nxt = '0;
        end else begin
          base_nxt = base_r + CNT_W'(fill_r[scan_r]);
          scan_nxt = scan_r - LIDX_W'(1);
        end
      end
      S_LD_RD: begin
        st_ra = ADDR_W'(base_r + CNT_W'(i_r));
        if (i_r == n_r) begin
          t_nxt = {{FILL_W{1'b0}}, cfg_offset};
          k_nxt = '0;
        end
      end
      S_LD_WT: begin
        v_nxt = st_rd;
        j_nxt = i_r;
      end
      S_SRT_RD: begin
        if (j_r == '0) begin
          sc_we = 1'b1;
          sc_wa = '0;
          sc_wd = v_r;
          i_nxt = i_r + FILL_W'(1);
        end
      end
      S_SRT_CMP: begin
        sc_we = 1'b1;
        sc_wa = j_r;
        if (srt_move) begin
          sc_wd = sc_rd;
          j_nxt = j_r - FILL_W'(1);
        end else begin
          sc_wd = v_r;
          i_nxt = i_r + FILL_W'(1);
        end
      end
      S_KEEP_RD: begin
        sc_ra = t_r[FILL_W-1:0];
        if (t_r >= {1'b0, n_r}) begin
          src_nxt  = base_r + CNT_W'(n_r);
          dst_nxt  = base_r + CNT_W'(k_r);
          left_nxt = stored_r - base_r - CNT_W'(n_r);
        end
      end
      S_KEEP_WR: begin
        st_we = 1'b1;
        st_wa = ADDR_W'(base_r + CNT_W'(k_r));
        st_wd = sc_rd;
        k_nxt = k_r + FILL_W'(1);
        t_nxt = t_r + (FILL_W+1)'(2);
      end
      S_MV_RD: begin
        st_ra = src_r[ADDR_W-1:0];
      end
      S_MV_WR: begin
        st_we    = 1'b1;
        st_wa    = dst_r[ADDR_W-1:0];
        st_wd    = st_rd;
        src_nxt  = src_r + CNT_W'(1);
        dst_nxt  = dst_r + CNT_W'(1);
        left_nxt = left_r - CNT_W'(1);
      end
      S_FIX: begin
        stored_nxt      = stored_r - CNT_W'(n_r) + CNT_W'(k_r);
        fill_nxt[lvl_r] = '0;
        if (!find_last) begin
          fill_nxt[LIDX_W'(lvl_r + LIDX_W'(1))] =
            fill_r[LIDX_W'(lvl_r + LIDX_W'(1))] + k_r;
        end else if (active_r < LVL_W'(MAX_LEVELS)) begin
          fill_nxt[active_r[LIDX_W-1:0]] = k_r;
          active_nxt = active_r + LVL_W'(1);
        end else begin
          // top level full: halved items stay where they are
          ovf_nxt         = 1'b1;
          fill_nxt[lvl_r] = k_r;
        end
      end
      S_Q_LV: begin
        st_ra = idx_r[ADDR_W-1:0];
        if (idx_r == stored_r) begin
          quo_nxt  = '0;
          rem_nxt  = {1'b0, below_r};
          dcnt_nxt = '0;
        end else if (qleft_r == '0) begin
          qlv_nxt   = qlv_dn;
          qleft_nxt = fill_r[qlv_dn];
        end
      end
      S_Q_ACC: begin
        tot_nxt = tot_r + qw;
        if ($signed(st_rd) <= $signed(qv_r)) begin
          below_nxt = below_r + qw;
        end
        idx_nxt   = idx_r + CNT_W'(1);
        qleft_nxt = qleft_r - FILL_W'(1);
      end
      S_DIV: begin
        quo_nxt  = {quo_r[FRAC_W-2:0], ge};
        rem_nxt  = {rem_keep, 1'b0};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          ocdf_nxt = quo_r;
          otot_nxt = (tot64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tot64[31:0];
          olvl_nxt = 5'(active_r);
          oovf_nxt = ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= LVL_W'(1);
      stored_r <= '0;
      ovf_r    <= 1'b0;
      ov_r     <= 1'b0;
      for (int l = 0; l < MAX_LEVELS; l++) fill_r[l] <= '0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      stored_r <= stored_nxt;
      ovf_r    <= ovf_nxt;
      ov_r     <= ov_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r   <= lvl_nxt;
    scan_r  <= scan_nxt;
    base_r  <= base_nxt;
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    t_r     <= t_nxt;
    v_r     <= v_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    left_r  <= left_nxt;
    qlv_r   <= qlv_nxt;
    qleft_r <= qleft_nxt;
    idx_r   <= idx_nxt;
    qv_r    <= qv_nxt;
    tot_r   <= tot_nxt;
    below_r <= below_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dcnt_r  <= dcnt_nxt;
    ocdf_r  <= ocdf_nxt;
    otot_r  <= otot_nxt;
    olvl_r  <= olvl_nxt;
    oovf_r  <= oovf_nxt;
  end

endmodule

// ===== rtl/streaming_quantile_sketch.sv =====
// channel   dir  handshake            payload
// in_       in   in_valid / in_stall  in_op, in_value
// out_      out  out_valid / out_stall out_cdf_fraction, out_total_weight,
//                                     out_levels_in_use, out_overflow
// cfg_      in   cfg_we               cfg_wdata (compaction offset)
//
// Insert: write, then a fill check; at summed capacity a compaction follows: a level scan, then
//   an insertion sort of the n-item level, a copy of the kept half, and a move of each item above.
// Query: a weighted pass over every stored item, level by level, then a bitwise divide, then delivery.
// Sync active-low reset; no clearing pass, the store is read only where filled.
// A 2-beat queue lets new beats land while the engine works; out_stall holds the
//   result register and the engine waits on it.
`include "streaming_quantile_sketch_defines.svh"

module streaming_quantile_sketch import sqs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_cdf_fraction,
  output logic [31:0] out_total_weight,
  output logic [4:0]  out_levels_in_use,
  output logic        out_overflow,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic      cfg_offset_r, cfg_offset_nxt;
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  sqs_stat_t stat;

  assign cfg_offset_nxt = cfg_we ? cfg_wdata : cfg_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_offset_r <= 1'b0;
    end else begin
      cfg_offset_r <= cfg_offset_nxt;
    end
  end

  sqs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .in_value  (in_value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  sqs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .cfg_offset        (cfg_offset_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cdf_fraction  (out_cdf_fraction),
    .out_total_weight  (out_total_weight),
    .out_levels_in_use (out_levels_in_use),
    .out_overflow      (out_overflow),
    .stat              (stat)
  );

  `SQS_ASSERT_NEXT(a_ovf_sticky, stat.ovf, stat.ovf)
  `SQS_ASSERT_SAME(a_ovf_top, stat.ovf, stat.active == LVL_W'(MAX_LEVELS))
  `SQS_ASSERT_NEXT(a_lvl_mono, 1'b1, stat.active >= $past(stat.active))
  `SQS_ASSERT_SAME(a_frac_range, out_valid, out_cdf_fraction <= 17'd65536)

endmodule
